FILE: hw/rtl/sync_header_crc8_deframer_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sync header CRC-8 deframer
// Shared by the files that carry concurrent checks.
// ----------------------------------------------------------------------------
`ifndef SYNC_HEADER_CRC8_DEFRAMER_TOP_MACROS_SVH
`define SYNC_HEADER_CRC8_DEFRAMER_TOP_MACROS_SVH

// check a consequent in the same cycle as its antecedent
`define SDCD_CHK_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// check a consequent in the cycle after its antecedent
`define SDCD_CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/sdcd_pkg.sv
// ----------------------------------------------------------------------------
// Sync header CRC-8 deframer package
// Types, codes, reset values and the CRC-8 byte update.
// ----------------------------------------------------------------------------
package sdcd_pkg;

	localparam int unsigned CMD_W    = 2;
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned STATUS_W = 3;
	localparam int unsigned GAP_W    = 16;
	localparam int unsigned COUNT_W  = 32;
	localparam int unsigned CFG_W    = 16;
	localparam int unsigned REG_IDX_W = 2;

	// link commands
	localparam logic [CMD_W-1:0] CMD_BYTE   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_TICK   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_RESYNC = 2'd2;

	// configuration register indexes
	localparam logic [REG_IDX_W-1:0] REG_GAP_LIMIT   = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_MAX_PAYLOAD = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_SYNC_FIRST  = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_SYNC_SECOND = 2'd3;

	// configuration reset values
	localparam logic [GAP_W-1:0]  RST_GAP_LIMIT   = 16'd50;
	localparam logic [BYTE_W-1:0] RST_MAX_PAYLOAD = 8'd250;
	localparam logic [BYTE_W-1:0] RST_SYNC_FIRST  = 8'hAB;
	localparam logic [BYTE_W-1:0] RST_SYNC_SECOND = 8'hCD;

	localparam logic [BYTE_W-1:0] CRC_POLY = 8'h07;

	typedef enum logic [STATUS_W-1:0] {
		ST_NONE    = 3'd0,
		ST_PAYLOAD = 3'd1,
		ST_GOOD    = 3'd2,
		ST_CRC_ERR = 3'd3,
		ST_LEN_ERR = 3'd4
	} status_t;

	typedef enum logic [5:0] {
		PH_SYNC1   = 6'b000001,
		PH_SYNC2   = 6'b000010,
		PH_TYPE    = 6'b000100,
		PH_LEN     = 6'b001000,
		PH_PAYLOAD = 6'b010000,
		PH_CRC     = 6'b100000
	} phase_t;

	typedef struct packed {
		logic [GAP_W-1:0]  gap_limit;
		logic [BYTE_W-1:0] max_payload;
		logic [BYTE_W-1:0] sync_first;
		logic [BYTE_W-1:0] sync_second;
	} cfg_t;

	typedef struct packed {
		status_t            status;
		logic [BYTE_W-1:0]  payload_byte;
		logic [BYTE_W-1:0]  payload_index;
		logic [BYTE_W-1:0]  frame_type;
		logic [BYTE_W-1:0]  frame_length;
		logic               gap_discard;
		logic [COUNT_W-1:0] good_frames;
		logic [COUNT_W-1:0] crc_errors;
	} res_t;

	// CRC-8, MSB first, one byte through eight shift steps
	function automatic logic [BYTE_W-1:0] crc8_feed(input logic [BYTE_W-1:0] crc,
			input logic [BYTE_W-1:0] data);
		logic [BYTE_W-1:0] c;
		c = crc ^ data;
		for (int k = 0; k < BYTE_W; k++) begin
			if (c[BYTE_W-1]) begin
				c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[BYTE_W-2:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

FILE: hw/rtl/sdcd_ifs.sv
// ----------------------------------------------------------------------------
// Sync header CRC-8 deframer channels
// Valid/ready channels for link commands and for results.
// ----------------------------------------------------------------------------
interface sdcd_link_if;
	import sdcd_pkg::*;

	logic                valid;
	logic                ready;
	logic [CMD_W-1:0]    command;
	logic [BYTE_W-1:0]   data_byte;

	modport source (output valid, command, data_byte, input ready);
	modport sink (input valid, command, data_byte, output ready);
endinterface

interface sdcd_report_if;
	import sdcd_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [BYTE_W-1:0]   payload_byte;
	logic [BYTE_W-1:0]   payload_index;
	logic [BYTE_W-1:0]   frame_type;
	logic [BYTE_W-1:0]   frame_length;
	logic                gap_discard;
	logic [COUNT_W-1:0]  good_frames;
	logic [COUNT_W-1:0]  crc_errors;

	modport source (output valid, status, payload_byte, payload_index, frame_type,
		frame_length, gap_discard, good_frames, crc_errors, input ready);
	modport sink (input valid, status, payload_byte, payload_index, frame_type,
		frame_length, gap_discard, good_frames, crc_errors, output ready);
endinterface

FILE: hw/rtl/sync_header_crc8_deframer_top.sv
// ----------------------------------------------------------------------------
// Sync header CRC-8 deframer: input stage, then registered result stage.
// One beat per cycle while results drain; phase and CRC update combinationally.
// Reset clears the stages, parser state and counters; registers take defaults.
// ----------------------------------------------------------------------------
`include "sync_header_crc8_deframer_top_macros.svh"

module sync_header_crc8_deframer_top (
	input  logic                          clk,
	input  logic                          arst_n,
	sdcd_link_if.sink                     link,
	sdcd_report_if.source                 report,
	input  logic                          cfg_we,
	input  logic [sdcd_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [sdcd_pkg::CFG_W-1:0]    cfg_data
);
	import sdcd_pkg::*;

	logic              s1_valid_q;
	logic [CMD_W-1:0]  cmd_s1;
	logic [BYTE_W-1:0] data_s1;
	logic              out_valid_q;
	res_t              res_s2;
	res_t              res;
	cfg_t              cfg;
	logic              advance;

	sdcd_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	sdcd_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.cmd    (cmd_s1),
		.data   (data_s1),
		.cfg    (cfg),
		.res    (res)
	);

	// process the held beat when the result register is free or draining
	assign advance    = s1_valid_q && (!out_valid_q || report.ready);
	assign link.ready = !s1_valid_q || advance;

	// input stage: take a new beat whenever ready
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (link.ready) begin
			s1_valid_q <= link.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (link.ready && link.valid) begin
			cmd_s1  <= link.command;
			data_s1 <= link.data_byte;
		end
	end

	// result stage: load on advance, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (report.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign report.valid         = out_valid_q;
	assign report.status        = res_s2.status;
	assign report.payload_byte  = res_s2.payload_byte;
	assign report.payload_index = res_s2.payload_index;
	assign report.frame_type    = res_s2.frame_type;
	assign report.frame_length  = res_s2.frame_length;
	assign report.gap_discard   = res_s2.gap_discard;
	assign report.good_frames   = res_s2.good_frames;
	assign report.crc_errors    = res_s2.crc_errors;

	`SDCD_CHK_NEXT(a_s1_held, clk, arst_n, s1_valid_q && !advance, s1_valid_q && $stable(cmd_s1) && $stable(data_s1), "stalled input beat lost")
	`SDCD_CHK_NEXT(a_result_loaded, clk, arst_n, advance, out_valid_q, "processed beat gave no result")
	`SDCD_CHK_NEXT(a_out_drained, clk, arst_n, out_valid_q && report.ready && !advance, !out_valid_q, "taken result repeated")

endmodule

FILE: hw/rtl/sdcd_cfg_regs.sv
// ----------------------------------------------------------------------------
// Deframer configuration registers
// Gap limit, largest payload and the two sync byte values.
// ----------------------------------------------------------------------------
module sdcd_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          we,
	input  logic [sdcd_pkg::REG_IDX_W-1:0] index,
	input  logic [sdcd_pkg::CFG_W-1:0]    data,
	output sdcd_pkg::cfg_t                cfg
);
	import sdcd_pkg::*;

	cfg_t cfg_q;

	// write the addressed register, keep the rest
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gap_limit   <= RST_GAP_LIMIT;
			cfg_q.max_payload <= RST_MAX_PAYLOAD;
			cfg_q.sync_first  <= RST_SYNC_FIRST;
			cfg_q.sync_second <= RST_SYNC_SECOND;
		end else if (we) begin
			case (index)
				REG_GAP_LIMIT:   cfg_q.gap_limit   <= data;
				REG_MAX_PAYLOAD: cfg_q.max_payload <= data[BYTE_W-1:0];
				REG_SYNC_FIRST:  cfg_q.sync_first  <= data[BYTE_W-1:0];
				REG_SYNC_SECOND: cfg_q.sync_second <= data[BYTE_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: hw/rtl/sdcd_parser.sv
// ----------------------------------------------------------------------------
// Deframer frame parser
// Phase machine, running CRC, gap timer and frame counters; one beat a step.
// ----------------------------------------------------------------------------
`include "sync_header_crc8_deframer_top_macros.svh"

module sdcd_parser (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        step,
	input  logic [sdcd_pkg::CMD_W-1:0]  cmd,
	input  logic [sdcd_pkg::BYTE_W-1:0] data,
	input  sdcd_pkg::cfg_t              cfg,
	output sdcd_pkg::res_t              res
);
	import sdcd_pkg::*;

	phase_t              phase_q, phase_n, phase_cur;
	logic [BYTE_W-1:0]   type_q, type_n;
	logic [BYTE_W-1:0]   len_q, len_n;
	logic [BYTE_W-1:0]   taken_q, taken_n;
	logic [BYTE_W-1:0]   crc_q, crc_n;
	logic [GAP_W-1:0]    idle_q, idle_n;
	logic [COUNT_W-1:0]  good_q, good_n;
	logic [COUNT_W-1:0]  err_q, err_n;
	logic                stale;
	logic                first_hit;
	status_t             status;
	logic [BYTE_W-1:0]   pbyte;
	logic [BYTE_W-1:0]   pindex;

	assign first_hit = (data == cfg.sync_first);

	// next state and result for one command
	always_comb begin
		phase_n   = phase_q;
		type_n    = type_q;
		len_n     = len_q;
		taken_n   = taken_q;
		crc_n     = crc_q;
		idle_n    = idle_q;
		good_n    = good_q;
		err_n     = err_q;
		stale     = 1'b0;
		phase_cur = phase_q;
		status    = ST_NONE;
		pbyte     = '0;
		pindex    = '0;
		case (cmd)
			CMD_TICK: begin
				if (idle_q != '1) begin
					idle_n = idle_q + 1'b1;
				end
			end
			CMD_RESYNC: begin
				phase_n = PH_SYNC1;
				taken_n = '0;
				crc_n   = '0;
			end
			CMD_BYTE: begin
				// drop a partial frame that has gone quiet too long
				stale     = (phase_q != PH_SYNC1) && (idle_q > cfg.gap_limit);
				phase_cur = stale ? PH_SYNC1 : phase_q;
				idle_n    = '0;
				case (phase_cur)
					PH_SYNC2: begin
						if (data == cfg.sync_second) begin
							phase_n = PH_TYPE;
						end else begin
							phase_n = first_hit ? PH_SYNC2 : PH_SYNC1;
						end
					end
					PH_TYPE: begin
						type_n  = data;
						crc_n   = crc8_feed('0, data);
						phase_n = PH_LEN;
					end
					PH_LEN: begin
						len_n   = data;
						taken_n = '0;
						if (data > cfg.max_payload) begin
							status  = ST_LEN_ERR;
							phase_n = PH_SYNC1;
						end else begin
							crc_n   = crc8_feed(crc_q, data);
							phase_n = (data == '0) ? PH_CRC : PH_PAYLOAD;
						end
					end
					PH_PAYLOAD: begin
						status  = ST_PAYLOAD;
						pbyte   = data;
						pindex  = taken_q;
						crc_n   = crc8_feed(crc_q, data);
						taken_n = taken_q + 1'b1;
						if (taken_n >= len_q) begin
							phase_n = PH_CRC;
						end
					end
					PH_CRC: begin
						if (crc_q == data) begin
							good_n = good_q + 1'b1;
							status = ST_GOOD;
						end else begin
							err_n  = err_q + 1'b1;
							status = ST_CRC_ERR;
						end
						phase_n = PH_SYNC1;
					end
					default: begin
						phase_n = first_hit ? PH_SYNC2 : PH_SYNC1;
					end
				endcase
			end
			default: ;
		endcase
	end

	// advance the parser state on each step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SYNC1;
			type_q  <= '0;
			len_q   <= '0;
			taken_q <= '0;
			crc_q   <= '0;
			idle_q  <= '0;
			good_q  <= '0;
			err_q   <= '0;
		end else if (step) begin
			phase_q <= phase_n;
			type_q  <= type_n;
			len_q   <= len_n;
			taken_q <= taken_n;
			crc_q   <= crc_n;
			idle_q  <= idle_n;
			good_q  <= good_n;
			err_q   <= err_n;
		end
	end

	always_comb begin
		res.status        = status;
		res.payload_byte  = pbyte;
		res.payload_index = pindex;
		res.frame_type    = type_n;
		res.frame_length  = len_n;
		res.gap_discard   = stale;
		res.good_frames   = good_n;
		res.crc_errors    = err_n;
	end

	`SDCD_CHK_NEXT(a_hold_without_step, clk, arst_n, !step, $stable(good_q) && $stable(err_q) && $stable(phase_q), "parser state moved without a step")
	`SDCD_CHK_NOW(a_payload_in_phase, clk, arst_n, step && (res.status == ST_PAYLOAD), (phase_q == PH_PAYLOAD) && !res.gap_discard, "payload beat outside payload phase")
	`SDCD_CHK_NOW(a_gap_quiet, clk, arst_n, res.gap_discard, (res.status == ST_NONE) && (cmd == CMD_BYTE), "gap drop with a non-empty result")

endmodule

FILE: sim/sync_header_crc8_deframer_top_tb.sv
// ----------------------------------------------------------------------------
// Sync header CRC-8 deframer testbench
// Drives link commands into the deframer and compares each result beat against
// a cycle-free model of the parser, its CRC-8 and its counters. Directed tests
// cover sync hunting, zero length, CRC and length errors, gap drops, resync,
// the unused command and the gap limit boundary. A back-pressure test and
// several randomised register settings follow.
// ----------------------------------------------------------------------------
module sync_header_crc8_deframer_top_tb;
	import sdcd_pkg::*;

	localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int SETTLE_CYCLES = 6;
	localparam int MAX_PRINTED   = 40;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [REG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	sdcd_link_if   link_ch ();
	sdcd_report_if report_ch ();

	sync_header_crc8_deframer_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.link      (link_ch),
		.report    (report_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// register copies, shared by the stimulus and the parser model
	logic [GAP_W-1:0]  cfg_gap_limit;
	logic [BYTE_W-1:0] cfg_max_payload;
	logic [BYTE_W-1:0] cfg_sync_first;
	logic [BYTE_W-1:0] cfg_sync_second;

	// parser model state
	phase_t             prs_phase;
	logic [BYTE_W-1:0]  prs_type;
	logic [BYTE_W-1:0]  prs_length;
	logic [BYTE_W-1:0]  prs_taken;
	logic [BYTE_W-1:0]  prs_crc;
	logic [GAP_W-1:0]   prs_idle;
	logic [COUNT_W-1:0] prs_good;
	logic [COUNT_W-1:0] prs_errors;

	res_t              pending_reports[$];
	res_t              predicted;
	res_t              oldest;
	logic [BYTE_W-1:0] frame_body[$];

	int  mismatch_count = 0;
	int  sent_items     = 0;
	int  link_beats     = 0;
	int  cycle_count    = 0;
	int  deepest_queue  = 0;
	int  settings_used  = 0;
	int  good_seen      = 0;
	int  crc_bad_seen   = 0;
	int  len_bad_seen   = 0;
	int  gap_drop_seen  = 0;
	int  hold_request   = 0;
	bit  gaps_on        = 1'b1;
	bit  stalls_on      = 1'b1;
	bit  frame_noise    = 1'b0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("sync_header_crc8_deframer_top verification failed");
			$finish;
		end
	end

	// CRC-8 poly 0x07, one data bit at a time, MSB first
	function automatic logic [BYTE_W-1:0] crc8_step(input logic [BYTE_W-1:0] acc,
			input logic [BYTE_W-1:0] data);
		logic [BYTE_W-1:0] c;
		logic              fb;
		c = acc;
		for (int k = BYTE_W - 1; k >= 0; k--) begin
			fb = c[BYTE_W-1] ^ data[k];
			c  = {c[BYTE_W-2:0], 1'b0} ^ (fb ? 8'h07 : 8'h00);
		end
		return c;
	endfunction

	task automatic reset_model();
		cfg_gap_limit   = RST_GAP_LIMIT;
		cfg_max_payload = RST_MAX_PAYLOAD;
		cfg_sync_first  = RST_SYNC_FIRST;
		cfg_sync_second = RST_SYNC_SECOND;
		prs_phase  = PH_SYNC1;
		prs_type   = '0;
		prs_length = '0;
		prs_taken  = '0;
		prs_crc    = '0;
		prs_idle   = '0;
		prs_good   = '0;
		prs_errors = '0;
	endtask

	// advance the parser model by one link beat and return its report
	function automatic res_t next_report(input logic [CMD_W-1:0] cmd,
			input logic [BYTE_W-1:0] b);
		res_t r;
		r = '0;
		case (cmd)
			CMD_TICK: begin
				if (prs_idle != 16'hFFFF) prs_idle = prs_idle + 16'd1;
			end
			CMD_RESYNC: begin
				prs_phase = PH_SYNC1;
				prs_taken = '0;
				prs_crc   = '0;
			end
			CMD_BYTE: begin
				// drop a stale partial frame, then treat the byte as hunting
				if (prs_phase != PH_SYNC1 && prs_idle > cfg_gap_limit) begin
					prs_phase     = PH_SYNC1;
					r.gap_discard = 1'b1;
				end
				prs_idle = '0;
				case (prs_phase)
					PH_SYNC2: begin
						if (b == cfg_sync_second) prs_phase = PH_TYPE;
						else if (b == cfg_sync_first) prs_phase = PH_SYNC2;
						else prs_phase = PH_SYNC1;
					end
					PH_TYPE: begin
						prs_type  = b;
						prs_crc   = crc8_step(8'h00, b);
						prs_phase = PH_LEN;
					end
					PH_LEN: begin
						prs_length = b;
						prs_taken  = '0;
						if (b > cfg_max_payload) begin
							r.status  = ST_LEN_ERR;
							prs_phase = PH_SYNC1;
						end else begin
							prs_crc = crc8_step(prs_crc, b);
							if (b == 8'd0) prs_phase = PH_CRC;
							else prs_phase = PH_PAYLOAD;
						end
					end
					PH_PAYLOAD: begin
						r.status        = ST_PAYLOAD;
						r.payload_byte  = b;
						r.payload_index = prs_taken;
						prs_crc   = crc8_step(prs_crc, b);
						prs_taken = prs_taken + 8'd1;
						if (prs_taken >= prs_length) prs_phase = PH_CRC;
					end
					PH_CRC: begin
						if (prs_crc == b) begin
							prs_good = prs_good + 32'd1;
							r.status = ST_GOOD;
						end else begin
							prs_errors = prs_errors + 32'd1;
							r.status   = ST_CRC_ERR;
						end
						prs_phase = PH_SYNC1;
					end
					default: begin
						if (b == cfg_sync_first) prs_phase = PH_SYNC2;
						else prs_phase = PH_SYNC1;
					end
				endcase
			end
			default: ;
		endcase
		r.frame_type   = prs_type;
		r.frame_length = prs_length;
		r.good_frames  = prs_good;
		r.crc_errors   = prs_errors;
		return r;
	endfunction

	// predict on every accepted link beat
	always @(posedge clk) begin
		if (arst_n && link_ch.valid && link_ch.ready) begin
			predicted = next_report(link_ch.command, link_ch.data_byte);
			pending_reports.push_back(predicted);
			link_beats++;
			if (pending_reports.size() > deepest_queue) deepest_queue = pending_reports.size();
			case (predicted.status)
				ST_GOOD:    good_seen++;
				ST_CRC_ERR: crc_bad_seen++;
				ST_LEN_ERR: len_bad_seen++;
				default: ;
			endcase
			if (predicted.gap_discard) gap_drop_seen++;
		end
	end

	task automatic note_mismatch(input string field, input logic [31:0] got,
			input logic [31:0] want);
		if (mismatch_count < MAX_PRINTED)
			$display("[%0d] mismatch on %s: got %0h, want %0h", cycle_count, field, got, want);
		mismatch_count++;
	endtask

	// compare each result beat with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && report_ch.valid && report_ch.ready) begin
			if (pending_reports.size() == 0) begin
				note_mismatch("unexpected result beat", report_ch.status, 0);
			end else begin
				oldest = pending_reports.pop_front();
				if (report_ch.status !== oldest.status)
					note_mismatch("status", report_ch.status, oldest.status);
				if (report_ch.payload_byte !== oldest.payload_byte)
					note_mismatch("payload_byte", report_ch.payload_byte, oldest.payload_byte);
				if (report_ch.payload_index !== oldest.payload_index)
					note_mismatch("payload_index", report_ch.payload_index, oldest.payload_index);
				if (report_ch.frame_type !== oldest.frame_type)
					note_mismatch("frame_type", report_ch.frame_type, oldest.frame_type);
				if (report_ch.frame_length !== oldest.frame_length)
					note_mismatch("frame_length", report_ch.frame_length, oldest.frame_length);
				if (report_ch.gap_discard !== oldest.gap_discard)
					note_mismatch("gap_discard", report_ch.gap_discard, oldest.gap_discard);
				if (report_ch.good_frames !== oldest.good_frames)
					note_mismatch("good_frames", report_ch.good_frames, oldest.good_frames);
				if (report_ch.crc_errors !== oldest.crc_errors)
					note_mismatch("crc_errors", report_ch.crc_errors, oldest.crc_errors);
			end
		end
	end

	// result side: random stall bursts, plus a long hold-off on request
	initial begin
		int stretch;
		report_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_request > 0) begin
				stretch      = hold_request;
				hold_request = 0;
				report_ch.ready <= 1'b0;
				repeat (stretch) @(posedge clk);
			end else if (stalls_on && $urandom_range(0, 11) == 0) begin
				report_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end else begin
				report_ch.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// offer one beat and hold it until accepted; valid stays high afterwards
	task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] b);
		if (gaps_on && $urandom_range(0, 11) == 0) begin
			link_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		link_ch.valid     <= 1'b1;
		link_ch.command   <= cmd;
		link_ch.data_byte <= b;
		@(posedge clk);
		while (!link_ch.ready) @(posedge clk);
		if (cmd != CMD_SPARE) sent_items++;
	endtask

	task automatic send_byte(input logic [BYTE_W-1:0] b);
		send_beat(CMD_BYTE, b);
	endtask

	task automatic send_ticks(input int n);
		repeat (n) send_beat(CMD_TICK, BYTE_W'($urandom));
	endtask

	// pause the link until every predicted result has come back
	task automatic drain_reports();
		link_ch.valid <= 1'b0;
		// let the prediction of the last accepted beat land first
		@(posedge clk);
		while (pending_reports.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		case (idx)
			REG_GAP_LIMIT:   cfg_gap_limit   = value;
			REG_MAX_PAYLOAD: cfg_max_payload = value[BYTE_W-1:0];
			REG_SYNC_FIRST:  cfg_sync_first  = value[BYTE_W-1:0];
			REG_SYNC_SECOND: cfg_sync_second = value[BYTE_W-1:0];
			default: ;
		endcase
	endtask

	task automatic apply_settings(input logic [GAP_W-1:0] gap, input logic [BYTE_W-1:0] maxp,
			input logic [BYTE_W-1:0] first, input logic [BYTE_W-1:0] second);
		drain_reports();
		write_reg(REG_GAP_LIMIT, gap);
		write_reg(REG_MAX_PAYLOAD, {8'h00, maxp});
		write_reg(REG_SYNC_FIRST, {8'h00, first});
		write_reg(REG_SYNC_SECOND, {8'h00, second});
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	// occasionally insert ticks between frame bytes, sometimes past the gap limit
	task automatic maybe_ticks();
		if (frame_noise && $urandom_range(0, 19) == 0) begin
			if ($urandom_range(0, 4) == 0 && cfg_gap_limit < 40) send_ticks(cfg_gap_limit + 1);
			else send_ticks($urandom_range(1, 3));
		end
	endtask

	// send sync, type, length, frame_body and CRC; with noise, may resync after the type
	task automatic send_frame(input logic [BYTE_W-1:0] ftype, input bit bad_crc);
		logic [BYTE_W-1:0] flen;
		logic [BYTE_W-1:0] crc;
		logic [BYTE_W-1:0] spoil;
		flen  = BYTE_W'(frame_body.size());
		spoil = BYTE_W'($urandom_range(1, 255));
		crc   = crc8_step(crc8_step(8'h00, ftype), flen);
		if (frame_noise && $urandom_range(0, 9) == 0) send_byte(cfg_sync_first);
		send_byte(cfg_sync_first);
		maybe_ticks();
		send_byte(cfg_sync_second);
		maybe_ticks();
		send_byte(ftype);
		if (frame_noise && $urandom_range(0, 32) == 0) begin
			send_beat(CMD_RESYNC, BYTE_W'($urandom));
			return;
		end
		maybe_ticks();
		send_byte(flen);
		foreach (frame_body[k]) begin
			maybe_ticks();
			send_byte(frame_body[k]);
			crc = crc8_step(crc, frame_body[k]);
		end
		maybe_ticks();
		send_byte(bad_crc ? (crc ^ spoil) : crc);
	endtask

	task automatic send_random_frame();
		int                len;
		int                cap;
		logic [BYTE_W-1:0] ftype;
		ftype = BYTE_W'($urandom);
		// oversize length byte
		if ($urandom_range(0, 99) < 8 && cfg_max_payload != 8'hFF) begin
			send_byte(cfg_sync_first);
			send_byte(cfg_sync_second);
			send_byte(ftype);
			send_byte(BYTE_W'($urandom_range(int'(cfg_max_payload) + 1, 255)));
			return;
		end
		cap = (cfg_max_payload < 10) ? int'(cfg_max_payload) : 10;
		if ($urandom_range(0, 99) < 4)
			len = $urandom_range(0, 1) ? int'(cfg_max_payload) : $urandom_range(0, cfg_max_payload);
		else
			len = $urandom_range(0, cap);
		frame_body.delete();
		repeat (len) frame_body.push_back(BYTE_W'($urandom));
		send_frame(ftype, $urandom_range(0, 99) < 15);
	endtask

	// mostly well-formed frames, the rest noise, ticks, resyncs, spare commands and truncations
	task automatic send_random_burst();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 70) begin
			send_random_frame();
		end else if (pick < 80) begin
			repeat ($urandom_range(1, 4)) send_byte(BYTE_W'($urandom));
		end else if (pick < 87) begin
			send_ticks($urandom_range(1, 3));
		end else if (pick < 93) begin
			send_beat(CMD_RESYNC, BYTE_W'($urandom));
		end else if (pick < 96) begin
			send_beat(CMD_SPARE, BYTE_W'($urandom));
		end else begin
			send_byte(cfg_sync_first);
			send_byte(cfg_sync_second);
			send_byte(BYTE_W'($urandom));
		end
	endtask

	task automatic run_phase(input logic [GAP_W-1:0] gap, input logic [BYTE_W-1:0] maxp,
			input logic [BYTE_W-1:0] first, input logic [BYTE_W-1:0] second, input int n);
		int target;
		apply_settings(gap, maxp, first, second);
		target = sent_items + n;
		while (sent_items < target) send_random_burst();
	endtask

	// repeated first sync, zero-length frame with zero type, reset registers
	task automatic test_sync_hunt();
		send_byte(RST_SYNC_FIRST);
		send_byte(RST_SYNC_FIRST);
		send_byte(RST_SYNC_SECOND);
		send_byte(8'h00);
		send_byte(8'h00);
		send_byte(crc8_step(crc8_step(8'h00, 8'h00), 8'h00));
	endtask

	// payload extremes with a wrong CRC byte
	task automatic test_crc_error();
		frame_body.delete();
		frame_body.push_back(8'h00);
		frame_body.push_back(8'hFF);
		send_frame(8'hFF, 1'b1);
	endtask

	// length one above the reset maximum
	task automatic test_length_error();
		send_byte(RST_SYNC_FIRST);
		send_byte(RST_SYNC_SECOND);
		send_byte(8'h11);
		send_byte(RST_MAX_PAYLOAD + 8'd1);
	endtask

	// zero gap limit drops on one tick; resync mid-header; unused command
	task automatic test_gap_and_resync();
		apply_settings(16'd0, RST_MAX_PAYLOAD, RST_SYNC_FIRST, RST_SYNC_SECOND);
		send_byte(RST_SYNC_FIRST);
		send_beat(CMD_TICK, 8'hFF);
		send_byte(RST_SYNC_SECOND);
		send_byte(RST_SYNC_FIRST);
		send_byte(RST_SYNC_SECOND);
		send_beat(CMD_RESYNC, 8'hA5);
		send_byte(RST_SYNC_SECOND);
		send_beat(CMD_SPARE, 8'hFF);
	endtask

	// hold the result side off while the link keeps offering beats
	task automatic test_back_pressure();
		apply_settings(RST_GAP_LIMIT, RST_MAX_PAYLOAD, RST_SYNC_FIRST, RST_SYNC_SECOND);
		frame_noise  = 1'b1;
		hold_request = 300;
		repeat (12) send_random_burst();
		drain_reports();
	endtask

	// silence up to the limit keeps a partial frame, one tick more drops it
	task automatic test_long_silence();
		gaps_on   = 1'b0;
		stalls_on = 1'b0;
		apply_settings(16'd20, RST_MAX_PAYLOAD, RST_SYNC_FIRST, RST_SYNC_SECOND);
		send_byte(RST_SYNC_FIRST);
		send_byte(RST_SYNC_SECOND);
		send_byte(8'h5A);
		send_ticks(20);
		send_byte(8'h02);
		send_ticks(21);
		send_byte(8'h33);
		drain_reports();
		gaps_on   = 1'b1;
		stalls_on = 1'b1;
	endtask

	task automatic test_random_traffic();
		frame_noise = 1'b1;
		run_phase(RST_GAP_LIMIT, RST_MAX_PAYLOAD, RST_SYNC_FIRST, RST_SYNC_SECOND, 400);
		run_phase(16'd3, 8'd16, BYTE_W'($urandom), BYTE_W'($urandom), 400);
		run_phase(16'd0, 8'd0, 8'h00, 8'hFF, 300);
		run_phase(16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 300);
		// closing stretch at full rate on both sides
		gaps_on   = 1'b0;
		stalls_on = 1'b0;
		run_phase(16'd7, 8'd40, BYTE_W'($urandom), BYTE_W'($urandom), 550);
	endtask

	initial begin
		arst_n            <= 1'b0;
		cfg_we            <= 1'b0;
		cfg_index         <= REG_GAP_LIMIT;
		cfg_data          <= '0;
		link_ch.valid     <= 1'b0;
		link_ch.command   <= CMD_BYTE;
		link_ch.data_byte <= '0;
		reset_model();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_sync_hunt();
		test_crc_error();
		test_length_error();
		test_gap_and_resync();
		test_back_pressure();
		test_long_silence();
		test_random_traffic();

		drain_reports();
		if (pending_reports.size() != 0)
			note_mismatch("results left outstanding", pending_reports.size(), 0);
		$display("Run covered %0d link beats over %0d register settings, result queue up to %0d.",
			link_beats, settings_used, deepest_queue);
		$display("Frames: %0d good, %0d CRC errors, %0d length errors, %0d gap drops.",
			good_seen, crc_bad_seen, len_bad_seen, gap_drop_seen);
		if (mismatch_count == 0) begin
			$display("sync_header_crc8_deframer_top verification clean");
		end else begin
			$display("sync_header_crc8_deframer_top verification failed");
		end
		$finish;
	end

endmodule
